// ===== sv/wrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrf_pkg: shared types and constants
// Sequencer states, mode and register codes, and the arctangent table used by
// the waypoint route follower.
// ----------------------------------------------------------------------------
package wrf_pkg;

   localparam int CNT_W = 9;   // waypoint count / index width
   localparam int DIF_W = 25;  // coordinate difference width
   localparam int PRD_W = 50;  // product width
   localparam int ACC_W = 52;  // cross / dot / rotation width
   localparam int ANG_W = 24;  // angle accumulator, 2^-20 rad

   localparam logic [1:0] MODE_WRITE   = 2'd0;
   localparam logic [1:0] MODE_RESTART = 2'd1;
   localparam logic [1:0] MODE_UPDATE  = 2'd2;

   localparam logic [1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [1:0] CSR_LOOP_ROUTE = 2'd1;

   localparam logic [4:0] MOD_LAST  = 5'd8;
   localparam logic [4:0] SQRT_LAST = 5'd24;
   localparam logic [4:0] ROT_LAST  = 5'd19;

   localparam logic signed [17:0] TURN_MAX = 18'sd25736;

   typedef enum logic [4:0] {
      S_IDLE, S_MOD, S_RD, S_DIFF, S_SQX, S_SQZ, S_SQD, S_CMP, S_SQRT,
      S_TR0, S_TR1, S_TR2, S_TR3, S_M1, S_M2, S_M3, S_M4, S_M5,
      S_NORM, S_ROT, S_RND, S_DONE
   } state_type;

   // cordic step angles in 2^-20 rad
   function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] i);
      logic signed [ANG_W-1:0] a;
      case (i)
         5'd0:  a = 24'sd823550;
         5'd1:  a = 24'sd486170;
         5'd2:  a = 24'sd256879;
         5'd3:  a = 24'sd130396;
         5'd4:  a = 24'sd65451;
         5'd5:  a = 24'sd32757;
         5'd6:  a = 24'sd16383;
         5'd7:  a = 24'sd8192;
         5'd8:  a = 24'sd4096;
         5'd9:  a = 24'sd2048;
         5'd10: a = 24'sd1024;
         5'd11: a = 24'sd512;
         5'd12: a = 24'sd256;
         5'd13: a = 24'sd128;
         5'd14: a = 24'sd64;
         5'd15: a = 24'sd32;
         5'd16: a = 24'sd16;
         5'd17: a = 24'sd8;
         5'd18: a = 24'sd4;
         5'd19: a = 24'sd2;
         default: a = 24'sd0;
      endcase
      return a;
   endfunction

endpackage

// ===== sv/wrf_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrf_store: waypoint table
// One write port and one registered read port for position and diameter.
// ----------------------------------------------------------------------------
module wrf_store import wrf_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic signed [23:0]   wr_x,
   input  logic signed [23:0]   wr_z,
   input  logic [15:0]          wr_d,
   input  logic [AW-1:0]        rd_addr,
   output logic signed [23:0]   rd_x,
   output logic signed [23:0]   rd_z,
   output logic [15:0]          rd_d
);

   logic [63:0] mem [DEPTH];
   logic [63:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_x, wr_z, wr_d};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_x = rd_ff[63:40];
   assign rd_z = rd_ff[39:16];
   assign rd_d = rd_ff[15:0];

endmodule

// ===== sv/wrf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrf_mul: shared multiplier
// Signed 25 x 25 multiply with a registered product.
// ----------------------------------------------------------------------------
module wrf_mul import wrf_pkg::*; (
   input  logic                      clock,
   input  logic signed [DIF_W-1:0]   op_a,
   input  logic signed [DIF_W-1:0]   op_b,
   output logic signed [PRD_W-1:0]   prod
);

   logic signed [PRD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

// ===== sv/waypoint_route_follower_core.sv =====
`timescale 1ns / 1ps
// sequence: a write, restart, no-op or finished route runs the modulo step and
//   then the result; a position update adds the capture tests and the root, and
//   at an inner waypoint the turn (table reads, multiplies, normalize, 20 cordic
//   rotations, round)
// throughput: one word at a time; busy stays high until the strobe, which lasts
//   one cycle and cannot be stalled; reset: synchronous, next waypoint to 1
// ----------------------------------------------------------------------------
// waypoint_route_follower_core: waypoint route follower
// Keeps a waypoint table, advances the target on capture and reports target,
// distance and turn angle, all on one shared multiplier and add/shift path.
// ----------------------------------------------------------------------------
module waypoint_route_follower_core import wrf_pkg::*; #(
   parameter int MAX_WAYPOINTS = 256
) (
   input  logic                clock,
   input  logic                reset,
   // command channel
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_mode,
   input  logic [7:0]          req_node_index,
   input  logic signed [23:0]  req_x_coord,
   input  logic signed [23:0]  req_z_coord,
   input  logic [15:0]         req_diameter,
   // result channel
   output logic                rsp_valid,
   output logic [8:0]          rsp_target_index,
   output logic                rsp_finished,
   output logic [24:0]         rsp_distance,
   output logic signed [15:0]  rsp_turn_angle,
   output logic                rsp_advance_capped,
   // register channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [8:0]          csr_wdata
);

   localparam int AW = $clog2(MAX_WAYPOINTS);
   localparam logic [12:0] MAX_C = 13'(MAX_WAYPOINTS);

   // registers
   state_type state_ff, state_in;
   logic [8:0]  node_count_ff;
   logic        loop_ff;
   logic [8:0]  next_ff, next_in;
   logic [8:0]  n_ff, t_ff, t_in, rem_ff, rem_in, adv_ff, adv_in;
   logic [1:0]  mode_ff;
   logic        fin_ff, fin_in, capped_ff, capped_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic signed [23:0] px_ff, pz_ff, prv_x_ff, prv_z_ff, cur_x_ff, cur_z_ff;
   logic signed [DIF_W-1:0] dx_ff, dz_ff, bx_ff, bz_ff;
   logic [15:0] diam_ff;
   logic [PRD_W-1:0] d2_ff, v_ff, r_ff;
   logic signed [ACC_W-1:0] cr_ff, dt_ff, cx_ff, cy_ff, m_ff;
   logic signed [ANG_W-1:0] ang_ff;
   logic [24:0] dist_ff;
   logic signed [15:0] turn_ff;
   logic        rsp_valid_ff;
   logic [8:0]  rsp_tgt_ff;
   logic        rsp_fin_ff, rsp_cap_ff;
   logic [24:0] rsp_dist_ff;
   logic signed [15:0] rsp_turn_ff;

   // combinational
   logic        accept;
   logic [12:0] nc_ext;
   logic [8:0]  n_eff;
   logic [16:0] mod_sub;
   logic [8:0]  t_inc, t_dec;
   logic signed [DIF_W-1:0] mul_a, mul_b;
   logic signed [PRD_W-1:0] prod;
   logic [8:0]  rd_idx;
   logic [AW+8:0] rd_ext, wr_ext;
   logic signed [23:0] rd_x, rd_z;
   logic [15:0] rd_d;
   logic        wr_en;
   logic        over;
   logic [PRD_W-1:0] bit_w, trial;
   logic signed [ACC_W-1:0] dt_abs, cr_abs, mag, dt_sum;
   logic signed [ANG_W-1:0] ang_rnd;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // effective waypoint count
   assign nc_ext = {4'b0, node_count_ff};
   always_comb begin
      if (node_count_ff == 9'd0) n_eff = 9'd1;
      else if (nc_ext > MAX_C)   n_eff = MAX_C[8:0];
      else                       n_eff = node_count_ff;
   end

   assign mod_sub = {8'b0, n_ff} << cnt_ff;
   assign t_inc   = t_ff + 9'd1;
   assign t_dec   = t_ff - 9'd1;
   assign over    = {d2_ff, 2'b00} > {2'b00, prod};
   assign bit_w   = PRD_W'(1) << {cnt_ff, 1'b0};
   assign trial   = r_ff + bit_w;
   assign dt_sum  = dt_ff + ACC_W'(prod);
   assign dt_abs  = dt_sum[ACC_W-1] ? -dt_sum : dt_sum;
   assign cr_abs  = cr_ff[ACC_W-1] ? -cr_ff : cr_ff;
   // magnitude is tracked on its own and halved by flooring
   assign mag     = m_ff;
   assign ang_rnd = (ang_ff + 24'sd32) >>> 6;

   // table
   assign wr_en  = accept && (req_mode == MODE_WRITE) && ({5'b0, req_node_index} < MAX_C);
   assign wr_ext = {{AW{1'b0}}, 1'b0, req_node_index};
   assign rd_ext = {{AW{1'b0}}, rd_idx};

   wrf_store #(.DEPTH(MAX_WAYPOINTS), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ext[AW-1:0]),
      .wr_x    (req_x_coord),
      .wr_z    (req_z_coord),
      .wr_d    (req_diameter),
      .rd_addr (rd_ext[AW-1:0]),
      .rd_x    (rd_x),
      .rd_z    (rd_z),
      .rd_d    (rd_d)
   );

   wrf_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_MOD;
         S_MOD: begin
            if (cnt_ff == 5'd0) begin
               state_in = (mode_ff == MODE_UPDATE && !fin_in) ? S_RD : S_DONE;
            end
         end
         S_RD:   state_in = S_DIFF;
         S_DIFF: state_in = S_SQX;
         S_SQX:  state_in = S_SQZ;
         S_SQZ:  state_in = S_SQD;
         S_SQD:  state_in = S_CMP;
         S_CMP: begin
            if (over || adv_ff == n_ff)          state_in = S_SQRT;
            else if (!loop_ff && t_inc >= n_ff)  state_in = S_DONE;
            else                                 state_in = S_RD;
         end
         S_SQRT: begin
            if (cnt_ff == 5'd0) begin
               state_in = (t_ff == 9'd0 || t_inc >= n_ff) ? S_DONE : S_TR0;
            end
         end
         S_TR0: state_in = S_TR1;
         S_TR1: state_in = S_TR2;
         S_TR2: state_in = S_TR3;
         S_TR3: state_in = S_M1;
         S_M1: begin
            // zero-length segment gives no turn
            if ((dx_ff == '0 && dz_ff == '0) || (bx_ff == '0 && bz_ff == '0))
               state_in = S_DONE;
            else
               state_in = S_M2;
         end
         S_M2: state_in = S_M3;
         S_M3: state_in = S_M4;
         S_M4: state_in = S_M5;
         S_M5: state_in = S_NORM;
         S_NORM: begin
            if (mag < (ACC_W'(1) <<< 29) && mag >= (ACC_W'(1) <<< 28)) state_in = S_ROT;
         end
         S_ROT:  if (cnt_ff == ROT_LAST) state_in = S_RND;
         S_RND:  state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // multiplier operands and table read address
   always_comb begin
      mul_a  = dx_ff;
      mul_b  = dx_ff;
      rd_idx = t_ff;
      case (state_ff)
         S_SQZ: begin mul_a = dz_ff; mul_b = dz_ff; end
         S_SQD: begin
            mul_a = $signed({9'b0, diam_ff});
            mul_b = $signed({9'b0, diam_ff});
         end
         S_M1:  begin mul_a = dx_ff; mul_b = bz_ff; end
         S_M2:  begin mul_a = bx_ff; mul_b = dz_ff; end
         S_M3:  begin mul_a = dx_ff; mul_b = bx_ff; end
         S_M4:  begin mul_a = dz_ff; mul_b = bz_ff; end
         S_TR0: rd_idx = t_dec;
         S_TR2: rd_idx = t_inc;
         default: ;
      endcase
   end

   // sequencer side values
   always_comb begin
      rem_in    = rem_ff;
      t_in      = t_ff;
      fin_in    = fin_ff;
      next_in   = next_ff;
      adv_in    = adv_ff;
      capped_in = capped_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rem_in    = (req_mode == MODE_RESTART) ? 9'd1 : next_ff;
               next_in   = rem_in;
               adv_in    = 9'd0;
               capped_in = 1'b0;
               cnt_in    = MOD_LAST;
            end
         end
         S_MOD: begin
            // restoring remainder, one bit a cycle
            if ({8'b0, rem_ff} >= mod_sub) rem_in = rem_ff - mod_sub[8:0];
            cnt_in = cnt_ff - 5'd1;
            fin_in = !loop_ff && (next_ff >= n_ff);
            if (cnt_ff == 5'd0) t_in = rem_in;
         end
         S_CMP: begin
            if (over) begin
               cnt_in = SQRT_LAST;
            end else if (adv_ff == n_ff) begin
               capped_in = 1'b1;
               cnt_in    = SQRT_LAST;
            end else begin
               next_in = t_inc;
               adv_in  = adv_ff + 9'd1;
               fin_in  = !loop_ff && (t_inc >= n_ff);
               t_in    = (t_inc == n_ff) ? 9'd0 : t_inc;
            end
         end
         S_SQRT: cnt_in = cnt_ff - 5'd1;
         S_NORM: cnt_in = 5'd0;
         S_ROT:  cnt_in = cnt_ff + 5'd1;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_ff       <= 9'd1;
         node_count_ff <= 9'd2;
         loop_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_ff      <= next_in;
         rsp_valid_ff <= (state_ff == S_DONE);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NODE_COUNT: node_count_ff <= csr_wdata;
               CSR_LOOP_ROUTE: loop_ff       <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      t_ff      <= t_in;
      fin_ff    <= fin_in;
      adv_ff    <= adv_in;
      capped_ff <= capped_in;
      cnt_ff    <= cnt_in;
      case (state_ff)
         S_IDLE: begin
            mode_ff <= req_mode;
            px_ff   <= req_x_coord;
            pz_ff   <= req_z_coord;
            n_ff    <= n_eff;
            dist_ff <= '0;
            turn_ff <= '0;
         end
         S_DIFF: begin
            dx_ff   <= {px_ff[23], px_ff} - {rd_x[23], rd_x};
            dz_ff   <= {pz_ff[23], pz_ff} - {rd_z[23], rd_z};
            diam_ff <= rd_d;
         end
         S_SQZ: d2_ff <= prod;
         S_SQD: d2_ff <= d2_ff + prod;
         S_CMP: begin
            v_ff <= d2_ff;
            r_ff <= '0;
         end
         S_SQRT: begin
            // one root bit a cycle
            if (v_ff >= trial) begin
               v_ff <= v_ff - trial;
               r_ff <= (r_ff >> 1) + bit_w;
            end else begin
               r_ff <= r_ff >> 1;
            end
            if (cnt_ff == 5'd0) begin
               dist_ff <= (v_ff >= trial) ? 25'((r_ff >> 1) + bit_w) : 25'(r_ff >> 1);
            end
         end
         S_TR1: begin prv_x_ff <= rd_x; prv_z_ff <= rd_z; end
         S_TR2: begin cur_x_ff <= rd_x; cur_z_ff <= rd_z; end
         S_TR3: begin
            // incoming segment in dx/dz, outgoing in bx/bz
            dx_ff <= {cur_x_ff[23], cur_x_ff} - {prv_x_ff[23], prv_x_ff};
            dz_ff <= {cur_z_ff[23], cur_z_ff} - {prv_z_ff[23], prv_z_ff};
            bx_ff <= {rd_x[23], rd_x} - {cur_x_ff[23], cur_x_ff};
            bz_ff <= {rd_z[23], rd_z} - {cur_z_ff[23], cur_z_ff};
         end
         S_M2: cr_ff <= ACC_W'(prod);
         S_M3: cr_ff <= cr_ff - ACC_W'(prod);
         S_M4: dt_ff <= ACC_W'(prod);
         S_M5: begin
            cx_ff  <= dt_abs;
            cy_ff  <= cr_ff;
            m_ff   <= (cr_abs > dt_abs) ? cr_abs : dt_abs;
            ang_ff <= '0;
         end
         S_NORM: begin
            if (mag >= (ACC_W'(1) <<< 29)) begin
               cx_ff <= cx_ff >>> 1;
               cy_ff <= cy_ff >>> 1;
               m_ff  <= m_ff >>> 1;
            end else if (mag < (ACC_W'(1) <<< 28)) begin
               cx_ff <= cx_ff <<< 1;
               cy_ff <= cy_ff <<< 1;
               m_ff  <= m_ff <<< 1;
            end
         end
         S_ROT: begin
            if (cy_ff > 0) begin
               cx_ff  <= cx_ff + (cy_ff >>> cnt_ff);
               cy_ff  <= cy_ff - (cx_ff >>> cnt_ff);
               ang_ff <= ang_ff + atan_lut(cnt_ff);
            end else begin
               cx_ff  <= cx_ff - (cy_ff >>> cnt_ff);
               cy_ff  <= cy_ff + (cx_ff >>> cnt_ff);
               ang_ff <= ang_ff - atan_lut(cnt_ff);
            end
         end
         S_RND: begin
            if (18'(ang_rnd) > TURN_MAX)       turn_ff <= 16'(TURN_MAX);
            else if (18'(ang_rnd) < -TURN_MAX) turn_ff <= 16'(-TURN_MAX);
            else                               turn_ff <= 16'(ang_rnd);
         end
         S_DONE: begin
            rsp_tgt_ff  <= fin_ff ? n_ff : t_ff;
            rsp_fin_ff  <= fin_ff;
            rsp_dist_ff <= fin_ff ? 25'd0 : dist_ff;
            rsp_turn_ff <= fin_ff ? 16'sd0 : turn_ff;
            rsp_cap_ff  <= capped_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_target_index   = rsp_tgt_ff;
   assign rsp_finished       = rsp_fin_ff;
   assign rsp_distance       = rsp_dist_ff;
   assign rsp_turn_angle     = rsp_turn_ff;
   assign rsp_advance_capped = rsp_cap_ff;

   // checks
   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (t_ff < n_ff))
      else $error("table read beyond waypoint count");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not raise busy");

   a_fin_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> (rsp_distance == 25'd0 && rsp_turn_angle == 16'sd0))
      else $error("finished route reports distance or turn");

   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: waypoint route follower core
// Loads the waypoint table, then drives write, restart and position words
// under several node count and loop settings. A scoreboard class predicts
// target, finished flag, distance, turn angle and advance cap for every word
// and compares them with each result strobe.
// ----------------------------------------------------------------------------
module testbench import wrf_pkg::*; ();

   // one expected or observed result word
   typedef struct packed {
      logic [8:0]         target_index;
      logic               finished;
      logic [24:0]        distance;
      logic signed [15:0] turn_angle;
      logic               advance_capped;
   } route_result_type;

   class route_scoreboard;
      localparam int SLOTS = 256;

      // shadow copy of the waypoint table and route state
      logic signed [23:0] wp_x [SLOTS];
      logic signed [23:0] wp_z [SLOTS];
      logic [15:0]        wp_dia [SLOTS];
      int unsigned        next_wp;
      logic [8:0]         node_count;
      logic               loop_route;

      route_result_type   pending [$];
      int                 errors;
      int                 results;
      int                 capped_seen;
      int                 finished_seen;
      int                 turns_seen;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            wp_x[i] = '0;
            wp_z[i] = '0;
            wp_dia[i] = '0;
         end
         next_wp = 1;
         node_count = 2;
         loop_route = 0;
         errors = 0;
         results = 0;
         capped_seen = 0;
         finished_seen = 0;
         turns_seen = 0;
      endfunction

      function int unsigned route_len();
         if (node_count < 1) return 1;
         if (node_count > SLOTS) return SLOTS;
         return node_count;
      endfunction

      function bit route_done();
         return (loop_route == 0) && (next_wp >= route_len());
      endfunction

      // waypoint the vehicle currently heads for (0 once the route is done)
      function int unsigned aim_slot();
         return route_done() ? 0 : next_wp % route_len();
      endfunction

      function void write_reg(logic [1:0] idx, logic [8:0] value);
         if (idx == CSR_NODE_COUNT) node_count = value;
         else if (idx == CSR_LOOP_ROUTE) loop_route = value[0];
      endfunction

      function longint unsigned range_sq(int unsigned t, longint px, longint pz);
         longint dx;
         longint dz;
         dx = px - longint'(wp_x[t]);
         dz = pz - longint'(wp_z[t]);
         return longint'(dx * dx) + longint'(dz * dz);
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // atan2(y, x) for x >= 0, in 2^-20 rad, 20 rotation steps
      function longint heading_atan(longint x, longint y);
         longint m;
         longint acc;
         longint a;
         longint nx;
         longint ny;
         int     step_ang [10];
         step_ang = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                      4096, 2048};
         m = (y < 0) ? -y : y;
         acc = 0;
         if (x > m) m = x;
         while (m >= (64'sd1 <<< 29)) begin
            x = x >>> 1;
            y = y >>> 1;
            m = m >>> 1;
         end
         while (m < (64'sd1 <<< 28)) begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
         end
         for (int i = 0; i < 20; i++) begin
            a = (i < 10) ? longint'(step_ang[i]) : (64'sd1 <<< (20 - i));
            if (y > 0) begin
               nx = x + (y >>> i);
               ny = y - (x >>> i);
               acc = acc + a;
            end else begin
               nx = x - (y >>> i);
               ny = y + (x >>> i);
               acc = acc - a;
            end
            x = nx;
            y = ny;
         end
         return acc;
      endfunction

      // signed turn at waypoint t, Q2.14
      function longint turn_at_slot(int unsigned t, int unsigned n);
         longint ax, az, bx, bz, cr, dt, q;
         if (t == 0 || t + 1 >= n) return 0;
         ax = longint'(wp_x[t]) - longint'(wp_x[t-1]);
         az = longint'(wp_z[t]) - longint'(wp_z[t-1]);
         bx = longint'(wp_x[t+1]) - longint'(wp_x[t]);
         bz = longint'(wp_z[t+1]) - longint'(wp_z[t]);
         if ((ax == 0 && az == 0) || (bx == 0 && bz == 0)) return 0;
         cr = ax * bz - bx * az;
         dt = ax * bx + az * bz;
         if (dt < 0) dt = -dt;
         q = (heading_atan(dt, cr) + 32) >>> 6;
         if (q > 25736) q = 25736;
         if (q < -25736) q = -25736;
         return q;
      endfunction

      // accepted command word: update the shadow state, queue its result
      function void note_word(logic [1:0] mode, logic [7:0] slot,
                              logic signed [23:0] x, logic signed [23:0] z,
                              logic [15:0] dia);
         route_result_type  r;
         int unsigned       n;
         int unsigned       t;
         int unsigned       adv;
         bit                fin;
         longint unsigned   lim;
         longint            turn;
         n = route_len();
         t = 0;
         r = '0;
         turn = 0;
         if (mode == MODE_WRITE) begin
            wp_x[slot] = x;
            wp_z[slot] = z;
            wp_dia[slot] = dia;
         end else if (mode == MODE_RESTART) begin
            next_wp = 1;
         end
         fin = route_done();
         if (!fin) t = next_wp % n;
         if (mode == MODE_UPDATE) begin
            adv = 0;
            while (!fin) begin
               lim = longint'(wp_dia[t]) * longint'(wp_dia[t]);
               if (4 * range_sq(t, x, z) > lim) break;
               if (adv == n) begin
                  r.advance_capped = 1'b1;
                  break;
               end
               next_wp = t + 1;
               adv++;
               fin = route_done();
               if (!fin) t = next_wp % n;
            end
            if (!fin) begin
               r.distance = 25'(int_sqrt(range_sq(t, x, z)));
               turn = turn_at_slot(t, n);
            end
         end
         r.target_index = 9'(fin ? n : t);
         r.finished = fin;
         r.turn_angle = turn[15:0];
         pending.push_back(r);
      endfunction

      task report_mismatch(string what, longint got, longint want);
         errors++;
         if (errors <= 30)
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     results, what, got, want);
      endtask

      task check_word(route_result_type got);
         route_result_type want;
         results++;
         if (pending.size() == 0) begin
            report_mismatch("unexpected word, target", got.target_index, -1);
            return;
         end
         want = pending.pop_front();
         if (got.target_index !== want.target_index)
            report_mismatch("target_index", got.target_index, want.target_index);
         if (got.finished !== want.finished)
            report_mismatch("finished", got.finished, want.finished);
         if (got.distance !== want.distance)
            report_mismatch("distance", got.distance, want.distance);
         if (got.turn_angle !== want.turn_angle)
            report_mismatch("turn_angle", got.turn_angle, want.turn_angle);
         if (got.advance_capped !== want.advance_capped)
            report_mismatch("advance_capped", got.advance_capped,
                            want.advance_capped);
         if (want.advance_capped) capped_seen++;
         if (want.finished) finished_seen++;
         if (want.turn_angle != 0) turns_seen++;
      endtask
   endclass

   // mode code the block treats as a no-op
   localparam logic [1:0] MODE_NOP = 2'd3;
   localparam int STALL_LIMIT = 20000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_mode;
   logic [7:0]         req_node_index;
   logic signed [23:0] req_x_coord;
   logic signed [23:0] req_z_coord;
   logic [15:0]        req_diameter;
   logic               rsp_valid;
   logic [8:0]         rsp_target_index;
   logic               rsp_finished;
   logic [24:0]        rsp_distance;
   logic signed [15:0] rsp_turn_angle;
   logic               rsp_advance_capped;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [8:0]         csr_wdata;

   route_scoreboard    route_sb;
   int                 words_sent;
   int                 idle_pct;
   int                 quiet_cycles;

   waypoint_route_follower_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_node_index     (req_node_index),
      .req_x_coord        (req_x_coord),
      .req_z_coord        (req_z_coord),
      .req_diameter       (req_diameter),
      .rsp_valid          (rsp_valid),
      .rsp_target_index   (rsp_target_index),
      .rsp_finished       (rsp_finished),
      .rsp_distance       (rsp_distance),
      .rsp_turn_angle     (rsp_turn_angle),
      .rsp_advance_capped (rsp_advance_capped),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // monitor: results are checked before the word accepted on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            route_sb.check_word('{rsp_target_index, rsp_finished, rsp_distance,
                                  rsp_turn_angle, rsp_advance_capped});
         if (start && !busy)
            route_sb.note_word(req_mode, req_node_index, req_x_coord,
                               req_z_coord, req_diameter);
         if (csr_valid && csr_ready)
            route_sb.write_reg(csr_index, csr_wdata);
      end
   end

   // watchdog: counts edges with no handshake of any kind
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d words outstanding",
                     route_sb.pending.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // drive one command word, sometimes after a random gap, and wait for acceptance
   task automatic send_word(logic [1:0] mode, logic [7:0] slot,
                            logic signed [23:0] x, logic signed [23:0] z,
                            logic [15:0] dia);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_node_index <= slot;
      req_x_coord <= x;
      req_z_coord <= z;
      req_diameter <= dia;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
      // sender idling regime: 35 percent, then 60, then none
      idle_pct = (words_sent < 430) ? 35 : (words_sent < 860) ? 60 : 0;
   endtask

   // hold off until every expected word has come back
   task automatic drain_route();
      start <= 1'b0;
      @(posedge clock);
      while (route_sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [8:0] value);
      drain_route();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // position update close to the current target, often inside capture
   task automatic track_word();
      int unsigned t;
      int          reach;
      logic signed [23:0] dx;
      logic signed [23:0] dz;
      t = route_sb.aim_slot();
      reach = route_sb.wp_dia[t] / 2 + $urandom_range(0, 64);
      dx = 24'($urandom_range(0, reach) - reach / 2);
      dz = 24'($urandom_range(0, reach) - reach / 2);
      send_word(MODE_UPDATE, 8'($urandom), route_sb.wp_x[t] + dx,
                route_sb.wp_z[t] + dz, 16'($urandom));
   endtask

   task automatic random_word();
      int unsigned r;
      int unsigned t;
      logic signed [23:0] cx;
      logic signed [23:0] cz;
      r = $urandom_range(0, 99);
      t = route_sb.aim_slot();
      if (r < 55) begin
         track_word();
      end else if (r < 63) begin
         send_word(MODE_UPDATE, 8'($urandom), 24'($urandom), 24'($urandom),
                   16'($urandom));
      end else if (r < 68) begin
         send_word(MODE_UPDATE, 8'($urandom), route_sb.wp_x[t], route_sb.wp_z[t],
                   16'($urandom));
      end else if (r < 80) begin
         // rewrite a slot, mostly as a short hop from its neighbor
         t = $urandom_range(0, route_sb.route_len() - 1);
         cx = route_sb.wp_x[t] + 24'($signed($urandom_range(0, 8191)) - 4096);
         cz = route_sb.wp_z[t] + 24'($signed($urandom_range(0, 8191)) - 4096);
         if ($urandom_range(0, 3) == 0) begin
            cx = 24'($urandom);
            cz = 24'($urandom);
         end
         send_word(MODE_WRITE, 8'((t + 1) % 256), cx, cz, 16'($urandom));
      end else if (r < 90) begin
         send_word(MODE_RESTART, 8'($urandom), 24'($urandom), 24'($urandom),
                   16'($urandom));
      end else begin
         send_word(MODE_NOP, 8'($urandom), 24'($urandom), 24'($urandom),
                   16'($urandom));
      end
   endtask

   // build a tight cluster on the first slots so every waypoint captures
   task automatic cluster_route(int unsigned count);
      for (int i = 0; i < count; i++)
         send_word(MODE_WRITE, 8'(i), 24'($signed($urandom_range(0, 4000)) - 2000),
                   24'($signed($urandom_range(0, 4000)) - 2000), 16'hFFFF);
   endtask

   int unsigned count_plan [10];
   logic        loop_plan [10];

   initial begin
      route_sb = new();
      words_sent = 0;
      idle_pct = 35;
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= MODE_WRITE;
      req_node_index <= '0;
      req_x_coord <= '0;
      req_z_coord <= '0;
      req_diameter <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_NODE_COUNT;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // load the whole table first so no read ever hits an unwritten slot
      for (int i = 0; i < 256; i++)
         send_word(MODE_WRITE, 8'(i), 24'($urandom), 24'($urandom), 16'($urandom));

      // directed: reset settings (two waypoints, no loop)
      send_word(MODE_WRITE, 1, 24'sh7FFFFF, -24'sh800000, 16'h0000);
      send_word(MODE_WRITE, 0, -24'sh800000, 24'sh7FFFFF, 16'hFFFF);
      send_word(MODE_UPDATE, 0, -24'sh800000, 24'sh7FFFFF, 0); // far: max range
      send_word(MODE_UPDATE, 0, 24'sh7FFFFF, -24'sh800000, 0); // zero diameter hit
      send_word(MODE_UPDATE, 0, 0, 0, 0);                      // finished route
      send_word(MODE_NOP, 8'hFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF);
      send_word(MODE_RESTART, 0, 0, 0, 0);
      send_word(MODE_UPDATE, 8'hFF, 24'sh000100, -24'sh000100, 16'hFFFF);
      // three-point route with a zero-length segment, then a real corner
      write_csr(CSR_NODE_COUNT, 9'd3);
      send_word(MODE_WRITE, 0, 0, 0, 16'd256);
      send_word(MODE_WRITE, 1, 0, 0, 16'd256);
      send_word(MODE_WRITE, 2, 24'sd5000, 24'sd5000, 16'd256);
      send_word(MODE_UPDATE, 0, 24'sd100, 24'sd100, 0);
      send_word(MODE_WRITE, 0, -24'sd5000, 0, 16'd256);
      send_word(MODE_UPDATE, 0, 24'sd300, -24'sd300, 0);
      send_word(MODE_WRITE, 2, 24'sd5000, 0, 16'd256);          // straight on
      send_word(MODE_UPDATE, 0, 24'sd300, -24'sd300, 0);
      send_word(MODE_WRITE, 2, -24'sd5000, 24'sd10, 16'd256);   // near reversal
      send_word(MODE_UPDATE, 0, 24'sd300, -24'sd300, 0);
      send_word(MODE_UPDATE, 0, 0, 0, 0);                       // capture slot 1

      // capped advance: looping cluster, then a single looping waypoint
      write_csr(CSR_LOOP_ROUTE, 9'd1);
      write_csr(CSR_NODE_COUNT, 9'd5);
      cluster_route(5);
      repeat (6) send_word(MODE_UPDATE, 0, 0, 0, 0);
      write_csr(CSR_NODE_COUNT, 9'd1);
      repeat (4) track_word();

      // random phases across node counts, extremes and out-of-range ones
      count_plan = '{2, 7, 0, 256, 511, 3, 300, 17, 1, 40};
      loop_plan  = '{0, 1, 0, 1, 0, 1, 1, 0, 1, 0};
      for (int p = 0; p < 10; p++) begin
         write_csr(CSR_LOOP_ROUTE, {8'h00, loop_plan[p]});
         write_csr(CSR_NODE_COUNT, 9'(count_plan[p]));
         if (p == 5 || p == 9) begin
            cluster_route(route_sb.route_len());
            write_csr(CSR_LOOP_ROUTE, 9'd1);
         end
         for (int k = 0; k < 85; k++) begin
            random_word();
            // pressure: sometimes wait for every result before going on
            if ($urandom_range(0, 99) == 0) drain_route();
         end
      end

      drain_route();
      repeat (20) @(posedge clock);
      $display("sent %0d words, checked %0d results", words_sent,
               route_sb.results);
      $display("covered %0d capped advances, %0d finished routes, %0d turns",
               route_sb.capped_seen, route_sb.finished_seen,
               route_sb.turns_seen);
      if (route_sb.errors == 0 && route_sb.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

// ===== waypoint_route_follower_core.f =====
sv/wrf_pkg.sv
sv/wrf_store.sv
sv/wrf_mul.sv
sv/waypoint_route_follower_core.sv
tb/sv/testbench.sv
